@@ rtl/ttn_pkg.sv @@
package ttn_pkg;

    // Default cap on the node count
    localparam int unsigned MAX_NODES_DEF = 256;

    localparam int unsigned ID_W    = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned PHASE_W = 3;
    // Child numbers reach 2*255 + 1 + 2 before the range check
    localparam int unsigned KID_W   = 10;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_INIT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ONE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ALL  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SENT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

    // Input opcodes
    localparam logic OP_READY = 1'b0;
    localparam logic OP_OK    = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_NODE_ID    = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] from_node;
    } in_word_t;

    typedef struct packed {
        logic               send_valid;
        logic [ID_W-1:0]    send_dest;
        logic [PHASE_W-1:0] phase_now;
        logic               last;
    } out_word_t;

    // Tree neighborhood of this node
    typedef struct packed {
        logic             has_par;
        logic [ID_W-1:0]  par;
        logic [1:0]       nk;
        logic [KID_W-1:0] kid0;
        logic [KID_W-1:0] kid1;
    } topo_t;

    // Results produced for one item
    typedef struct packed {
        logic      two;
        out_word_t w0;
        out_word_t w1;
    } step_res_t;

endpackage

@@ rtl/ttn_topo.sv @@
module ttn_topo #(
    parameter int unsigned MAX_NODES = ttn_pkg::MAX_NODES_DEF
) (
    input  logic [ttn_pkg::ID_W-1:0]    node_id,
    input  logic [ttn_pkg::COUNT_W-1:0] node_count,
    output ttn_pkg::topo_t              topo
);

    // node_count can never exceed its own range, so a larger cap is a no-op
    localparam int unsigned CNT_MAX = (1 << ttn_pkg::COUNT_W) - 1;
    localparam logic [ttn_pkg::COUNT_W-1:0] CAP =
        (MAX_NODES > CNT_MAX) ? ttn_pkg::COUNT_W'(CNT_MAX)
                              : ttn_pkg::COUNT_W'(MAX_NODES);

    logic [ttn_pkg::COUNT_W-1:0] lim;
    logic [ttn_pkg::KID_W-1:0]   id_x;
    logic [ttn_pkg::KID_W-1:0]   left;
    logic [ttn_pkg::KID_W-1:0]   right;
    logic [ttn_pkg::KID_W-1:0]   lim_x;
    logic                        left_ok;
    logic                        right_ok;
    logic [ttn_pkg::ID_W-1:0]    half;

    always_comb begin
        lim  = (node_count > CAP) ? CAP : node_count;
        id_x = ttn_pkg::KID_W'(node_id);
        if (node_id == '0) begin
            left  = ttn_pkg::KID_W'(1);
            right = ttn_pkg::KID_W'(2);
        end else begin
            left  = (id_x << 1) + ttn_pkg::KID_W'(node_id[0]);
            right = (id_x << 1) + ttn_pkg::KID_W'(2) + ttn_pkg::KID_W'(node_id[0]);
        end
        lim_x    = ttn_pkg::KID_W'(lim);
        left_ok  = left < lim_x;
        right_ok = right < lim_x;

        // parent: n/2, one lower when parities differ; node 1 hangs off the root
        half = node_id >> 1;
        if (half[0] != node_id[0]) begin
            half = half - ttn_pkg::ID_W'(1);
        end

        topo.has_par = (node_id != '0);
        topo.par     = (node_id == ttn_pkg::ID_W'(1)) ? '0 : half;
        topo.nk      = {1'b0, left_ok} + {1'b0, right_ok};
        topo.kid0    = left;
        topo.kid1    = right;
    end

endmodule

@@ rtl/ttn_step.sv @@
module ttn_step (
    input  ttn_pkg::in_word_t             item,
    input  ttn_pkg::topo_t                topo,
    input  logic [ttn_pkg::PHASE_W-1:0]   phase,
    output logic [ttn_pkg::PHASE_W-1:0]   phase_next,
    output ttn_pkg::step_res_t            res
);

    logic up;
    logic down;
    logic is_kid;

    always_comb begin
        up         = 1'b0;
        down       = 1'b0;
        phase_next = phase;
        is_kid = ((topo.nk != 2'd0) &&
                  (topo.kid0 == ttn_pkg::KID_W'(item.from_node))) ||
                 ((topo.nk == 2'd2) &&
                  (topo.kid1 == ttn_pkg::KID_W'(item.from_node)));

        if (item.opcode == ttn_pkg::OP_READY) begin
            if (topo.nk == 2'd0 && phase == ttn_pkg::PH_INIT) begin
                // leaf reports up; a lone root just finishes
                up         = topo.has_par;
                phase_next = topo.has_par ? ttn_pkg::PH_SENT : ttn_pkg::PH_DONE;
            end else if (phase == ttn_pkg::PH_ALL) begin
                up         = topo.has_par;
                down       = !topo.has_par;
                phase_next = topo.has_par ? ttn_pkg::PH_SENT : ttn_pkg::PH_DONE;
            end
        end else begin
            case (phase)
                ttn_pkg::PH_INIT: begin
                    if (is_kid) begin
                        phase_next = (topo.nk == 2'd1) ? ttn_pkg::PH_ALL : ttn_pkg::PH_ONE;
                    end
                end
                ttn_pkg::PH_ONE: begin
                    if (is_kid) begin
                        phase_next = ttn_pkg::PH_ALL;
                    end
                end
                ttn_pkg::PH_SENT: begin
                    if (topo.has_par && item.from_node == topo.par) begin
                        down       = 1'b1;
                        phase_next = ttn_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        res.two           = 1'b0;
        res.w0.send_valid = 1'b0;
        res.w0.send_dest  = '0;
        res.w0.phase_now  = phase_next;
        res.w0.last       = 1'b1;
        res.w1.send_valid = 1'b1;
        res.w1.send_dest  = topo.kid1[ttn_pkg::ID_W-1:0];
        res.w1.phase_now  = phase_next;
        res.w1.last       = 1'b1;

        if (up) begin
            res.w0.send_valid = 1'b1;
            res.w0.send_dest  = topo.par;
        end else if (down && topo.nk != 2'd0) begin
            res.w0.send_valid = 1'b1;
            res.w0.send_dest  = topo.kid0[ttn_pkg::ID_W-1:0];
            res.w0.last       = (topo.nk == 2'd1);
            res.two           = (topo.nk == 2'd2);
        end
    end

endmodule

@@ rtl/ttn_outbuf.sv @@
module ttn_outbuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ttn_pkg::step_res_t  res,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output ttn_pkg::out_word_t  m_word
);

    logic [1:0]         cnt_reg, cnt_next;
    ttn_pkg::out_word_t head_reg, head_next;
    ttn_pkg::out_word_t tail_reg, tail_next;

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_word   = head_reg;
    assign can_push = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push) begin
            head_next = res.w0;
            tail_next = res.w1;
            cnt_next  = res.two ? 2'd2 : 2'd1;
        end else if (m_valid && m_ready) begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ rtl/tree_termination_node.sv @@
// tree_termination_node: one node of a binary-tree termination handshake.
//
// Config (APB, pready tied high): 0x0 node_id, 0x4 node_count. Write only
// while the node is idle. Topology (parent, up to two children) follows
// from these two registers combinationally.
// Input channel s_valid/s_ready/s_word: a local ready request or an OK
// received from from_node. Output channel m_valid/m_ready/m_word: one or two
// words per item, last set on the final one.
// Input accept to first output word: input register, then one pass of
// phase/route logic into the output buffer. Throughput: one item per cycle
// while m_ready is high; an item that fans OK out to two children holds the
// output buffer until both words leave, set by its single read port.
// Reset (aresetn low, synchronous): phase back to init, node_id 0,
// node_count 1, both stages emptied.
// Receiver stall: the output buffer holds its words; the input register
// keeps one more item, then s_ready drops until the buffer drains.
module tree_termination_node #(
    parameter int unsigned MAX_NODES = ttn_pkg::MAX_NODES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // item input
    input  logic                s_valid,
    output logic                s_ready,
    input  ttn_pkg::in_word_t   s_word,
    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output ttn_pkg::out_word_t  m_word
);

    logic [ttn_pkg::ID_W-1:0]    node_id_reg;
    logic [ttn_pkg::COUNT_W-1:0] node_count_reg;
    logic [ttn_pkg::PHASE_W-1:0] phase_reg;
    logic [ttn_pkg::PHASE_W-1:0] phase_next;
    ttn_pkg::in_word_t           in_reg;
    logic                        in_valid_reg;

    ttn_pkg::topo_t     topo;
    ttn_pkg::step_res_t res;
    logic               can_push;
    logic               advance;
    logic               cfg_wr;

    // ---------------- config registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            ttn_pkg::REG_NODE_ID:    prdata = 32'(node_id_reg);
            ttn_pkg::REG_NODE_COUNT: prdata = 32'(node_count_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= '0;
            node_count_reg <= ttn_pkg::COUNT_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == ttn_pkg::REG_NODE_ID) begin
                node_id_reg <= pwdata[ttn_pkg::ID_W-1:0];
            end else begin
                node_count_reg <= pwdata[ttn_pkg::COUNT_W-1:0];
            end
        end
    end

    // ---------------- input register ----------------
    // the held item moves on whenever the output buffer can take its words
    assign advance = in_valid_reg && can_push;
    assign s_ready = !in_valid_reg || can_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= ttn_pkg::PH_INIT;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg <= phase_next;
            end
        end
        if (s_valid && s_ready) begin
            in_reg <= s_word;
        end
    end

    // ---------------- tree neighborhood and phase logic ----------------
    ttn_topo #(
        .MAX_NODES (MAX_NODES)
    ) u_topo (
        .node_id    (node_id_reg),
        .node_count (node_count_reg),
        .topo       (topo)
    );

    ttn_step u_step (
        .item       (in_reg),
        .topo       (topo),
        .phase      (phase_reg),
        .phase_next (phase_next),
        .res        (res)
    );

    // ---------------- output buffer (one or two words) ----------------
    ttn_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (advance),
        .res      (res),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

`ifndef SYNTHESIS
    // phase never leaves the five defined codes
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= ttn_pkg::PH_DONE)
        else $error("phase out of range");

    // terminated is final until reset
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == ttn_pkg::PH_DONE |=> phase_reg == ttn_pkg::PH_DONE)
        else $error("left terminated phase");

    // a non-final word only occurs in a fan-out to two children
    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.last |->
            m_word.send_valid && m_word.phase_now == ttn_pkg::PH_DONE)
        else $error("bad first word of a pair");

    // an empty result is always the only word of its item
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.send_valid |-> m_word.last && m_word.send_dest == '0)
        else $error("empty result not last");
`endif

endmodule
